### rtl/core/bao_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and control structs for the binarize and open image block.
package bao_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int CHAN_W      = 8;
  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
  localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
  localparam int QUEUE_DEPTH = 2;

  localparam int REG_IDX_W = 2;
  localparam int APB_AW    = REG_IDX_W + 2;
  localparam int APB_DW    = 32;

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = REG_IDX_W'(2);

  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = CHAN_W'(200);
  localparam logic [DIM_W-1:0]  WIDTH_RESET     = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET    = DIM_W'(480);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              drain;
  } in_t;

  typedef struct packed {
    logic white;
    logic last;
  } out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] threshold;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  lag;
    logic [CNT_W-1:0]  estart;
    logic [CNT_W-1:0]  last_t;
    logic              busy;
  } cfg_t;

  typedef struct packed {
    logic             bin;
    logic             e_border;
    logic             k_up;
    logic             k_down;
    logic             k_left;
    logic             k_right;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] col;
  } op_t;

endpackage

### rtl/core/bao_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, binarizes pixels and tags each with its frame positions.
module bao_front import bao_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic restart_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  input  logic q_full_i,
  output logic q_push_o,
  output op_t  q_op_o
);

  logic [CNT_W-1:0] t_q, t_d;
  logic [COL_W-1:0] tc_q, tc_d;
  logic [COL_W-1:0] ec_q, ec_d;
  logic [ROW_W-1:0] er_q, er_d;
  logic [COL_W-1:0] kc_q, kc_d;
  logic [ROW_W-1:0] kr_q, kr_d;

  logic [DIM_W-1:0] w_m1, h_m1;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic             accept, pix, e_on, emit, fin, white;

  assign w_m1     = cfg_i.width - DIM_W'(1);
  assign h_m1     = cfg_i.height - DIM_W'(1);
  assign col_last = w_m1[COL_W-1:0];
  assign row_last = ROW_W'(h_m1);

  assign in_ready_o = !q_full_i && !cfg_i.busy;
  assign accept     = in_valid_i && in_ready_o;

  assign pix   = t_q < cfg_i.total;
  assign e_on  = t_q >= cfg_i.estart;
  assign emit  = t_q >= cfg_i.lag;
  assign fin   = t_q == cfg_i.last_t;
  assign white = pix && !in_data_i.drain &&
                 ((in_data_i.red > cfg_i.threshold) ||
                  (in_data_i.green > cfg_i.threshold) ||
                  (in_data_i.blue > cfg_i.threshold));

  always_comb begin
    q_op_o.bin      = white;
    q_op_o.e_border = (er_q == '0) || (er_q == row_last) ||
                      (ec_q == '0) || (ec_q == col_last);
    q_op_o.k_up     = kr_q != '0;
    q_op_o.k_down   = kr_q != row_last;
    q_op_o.k_left   = kc_q != '0;
    q_op_o.k_right  = kc_q != col_last;
    q_op_o.emit     = emit;
    q_op_o.last     = fin;
    q_op_o.col      = tc_q;
  end

  assign q_push_o = accept;

  always_comb begin
    t_d  = t_q;
    tc_d = tc_q;
    ec_d = ec_q;
    er_d = er_q;
    kc_d = kc_q;
    kr_d = kr_q;
    if (restart_i || (accept && fin)) begin
      t_d  = '0;
      tc_d = '0;
      ec_d = '0;
      er_d = '0;
      kc_d = '0;
      kr_d = '0;
    end else if (accept) begin
      t_d  = t_q + CNT_W'(1);
      tc_d = (tc_q == col_last) ? '0 : tc_q + COL_W'(1);
      if (e_on) begin
        if (ec_q == col_last) begin
          ec_d = '0;
          er_d = er_q + ROW_W'(1);
        end else begin
          ec_d = ec_q + COL_W'(1);
        end
      end
      if (emit) begin
        if (kc_q == col_last) begin
          kc_d = '0;
          kr_d = kr_q + ROW_W'(1);
        end else begin
          kc_d = kc_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q  <= '0;
      tc_q <= '0;
      ec_q <= '0;
      er_q <= '0;
      kc_q <= '0;
      kr_q <= '0;
    end else begin
      t_q  <= t_d;
      tc_q <= tc_d;
      ec_q <= ec_d;
      er_q <= er_d;
      kc_q <= kc_d;
      kr_q <= kr_d;
    end
  end

endmodule

### rtl/core/bao_queue.sv
`timescale 1ns / 1ps
// Short queue of tagged requests between the front end and the window pipeline.
module bao_queue import bao_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CQ_W  = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_W-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CQ_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CQ_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CQ_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/bao_window.sv
`timescale 1ns / 1ps
// Two-line memory and column registers that form a 3x3 window over a one-bit raster stream.
module bao_window import bao_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] raddr_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] waddr_i,
  input  logic             bit_i,
  output logic [8:0]       win_o
);

  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] mem_rd_q;
  logic       byp_q;
  logic [1:0] byp_data_q;
  logic [1:0] rd;
  logic [1:0] wdata;
  logic [2:0] cur;
  logic [2:0] c0_q, c1_q;

  assign rd    = byp_q ? byp_data_q : mem_rd_q;
  assign wdata = {rd[0], bit_i};
  assign cur   = {bit_i, rd[0], rd[1]};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem[waddr_i] <= wdata;
    end
    if (rd_en_i) begin
      mem_rd_q <= line_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= wdata;
    end
    if (wr_en_i) begin
      c0_q <= c1_q;
      c1_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (waddr_i == raddr_i);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_o[3*r]     = c0_q[r];
      win_o[3*r + 1] = c1_q[r];
      win_o[3*r + 2] = cur[r];
    end
  end

endmodule

### rtl/core/bao_back.sv
`timescale 1ns / 1ps
// Back end: erosion window, cross-shaped cleanup window and the output register.
module bao_back import bao_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  op_t  q_op_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef struct packed {
    logic             ero;
    logic             k_up;
    logic             k_down;
    logic             k_left;
    logic             k_right;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] col;
  } s2_t;

  logic       adv;
  logic       s1_valid_q;
  op_t        s1_op_q;
  logic       s2_valid_q;
  s2_t        s2_q, s2_d;
  logic       out_valid_q;
  out_t       out_data_q;
  logic [8:0] bin_win, ero_win;
  logic       cleaned;

  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  bao_window u_bin_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (adv),
    .raddr_i (q_op_i.col),
    .wr_en_i (adv && s1_valid_q),
    .waddr_i (s1_op_q.col),
    .bit_i   (s1_op_q.bin),
    .win_o   (bin_win)
  );

  always_comb begin
    s2_d.ero     = bin_win[4] && (s1_op_q.e_border || (&bin_win));
    s2_d.k_up    = s1_op_q.k_up;
    s2_d.k_down  = s1_op_q.k_down;
    s2_d.k_left  = s1_op_q.k_left;
    s2_d.k_right = s1_op_q.k_right;
    s2_d.emit    = s1_op_q.emit;
    s2_d.last    = s1_op_q.last;
    s2_d.col     = s1_op_q.col;
  end

  bao_window u_ero_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (adv),
    .raddr_i (s1_op_q.col),
    .wr_en_i (adv && s2_valid_q),
    .waddr_i (s2_q.col),
    .bit_i   (s2_q.ero),
    .win_o   (ero_win)
  );

  assign cleaned = ero_win[4] &&
                   (!s2_q.k_up    || ero_win[1]) &&
                   (!s2_q.k_down  || ero_win[7]) &&
                   (!s2_q.k_left  || ero_win[3]) &&
                   (!s2_q.k_right || ero_win[5]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q          <= q_op_i;
      s2_q             <= s2_d;
      out_data_q.white <= cleaned;
      out_data_q.last  <= s2_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_q.emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/binarize_and_open_image.sv
`timescale 1ns / 1ps
// Top level: register port, frame geometry and the front, queue and back of the pixel cleaner.
//
// Pixels enter in raster order at one request per clock while in_ready_o is high and are
// thresholded to one bit (white when any channel is above the threshold); a 3x3 erosion
// and then a cross-shaped cleanup run over two-line memories, so the result for pixel k
// leaves with request k + 2*width + 2 of the frame, and drain requests push out the last
// 2*width + 2 results. A result passes the request queue, the line-memory read stages and
// the output register before it is on out_valid_o. A write to the threshold, width or height
// register restarts the frame and holds in_ready_o low while the frame size products settle.
module binarize_and_open_image import bao_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CHAN_W-1:0]    threshold_q;
  logic [DIM_W-1:0]     image_width_q, image_height_q;
  logic [CNT_W-1:0]     total_q, lag_q, estart_q, last_t_q;
  logic [1:0]           settle_q;
  logic [2*DIM_W-1:0]   area;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_we, restart;
  logic [DIM_W-1:0]     dim_val;
  cfg_t                 cfg;
  logic                 q_push, q_full, q_pop, q_valid;
  op_t                  front_op, head_op;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite;
  assign dim_val = pwdata[DIM_W-1:0];
  assign restart = cfg_we &&
                   ((reg_idx == REG_THRESHOLD) || (reg_idx == REG_WIDTH) ||
                    (reg_idx == REG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= THRESHOLD_RESET;
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_THRESHOLD: threshold_q    <= pwdata[CHAN_W-1:0];
        REG_WIDTH:     image_width_q  <= clamp_dim(dim_val, MAX_WIDTH);
        REG_HEIGHT:    image_height_q <= clamp_dim(dim_val, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(threshold_q);
      REG_WIDTH:     prdata = APB_DW'(image_width_q);
      REG_HEIGHT:    prdata = APB_DW'(image_height_q);
      default:       prdata = '0;
    endcase
  end

  assign area = image_width_q * image_height_q;

  always_ff @(posedge clk_i) begin
    total_q  <= area[CNT_W-1:0];
    lag_q    <= CNT_W'({image_width_q, 1'b0}) + CNT_W'(2);
    estart_q <= CNT_W'(image_width_q) + CNT_W'(1);
    last_t_q <= total_q + lag_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'b11;
    end else if (restart) begin
      settle_q <= 2'b11;
    end else begin
      settle_q <= {1'b0, settle_q[1]};
    end
  end

  always_comb begin
    cfg.threshold = threshold_q;
    cfg.width     = image_width_q;
    cfg.height    = image_height_q;
    cfg.total     = total_q;
    cfg.lag       = lag_q;
    cfg.estart    = estart_q;
    cfg.last_t    = last_t_q;
    cfg.busy      = settle_q != 2'b00;
  end

  bao_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (front_op)
  );

  bao_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (head_op)
  );

  bao_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (head_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
